### rtl/tocmc_pkg.sv
// ----------------------------------------------------------------------------
// tocmc_pkg
// Shared types, constants and the distance table for the tour crossover block.
// ----------------------------------------------------------------------------
`default_nettype none

package tocmc_pkg;

    localparam int CITY_BITS      = 3;
    localparam int NUM_CODES      = 1 << CITY_BITS;
    localparam int NUM_CITIES_DEF = 6;
    localparam int COST_BITS      = 8;
    localparam int DIST_BITS      = 6;
    localparam int DIST_MAX       = 40;

    typedef logic [CITY_BITS-1:0] t_city;
    typedef logic [DIST_BITS-1:0] t_dist;
    typedef logic [COST_BITS-1:0] t_cost;

    localparam t_cost COST_MAX = {COST_BITS{1'b1}};

    // pipeline control handed to each stage group
    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

    // padded to every city code, unknown cities cost nothing
    localparam t_dist DIST_ROM [NUM_CODES][NUM_CODES] = '{
        '{6'd0,  6'd10, 6'd15, 6'd20, 6'd25, 6'd30, 6'd0, 6'd0},
        '{6'd10, 6'd0,  6'd35, 6'd25, 6'd15, 6'd5,  6'd0, 6'd0},
        '{6'd15, 6'd35, 6'd0,  6'd30, 6'd20, 6'd10, 6'd0, 6'd0},
        '{6'd20, 6'd25, 6'd30, 6'd0,  6'd5,  6'd10, 6'd0, 6'd0},
        '{6'd25, 6'd15, 6'd20, 6'd5,  6'd0,  6'd40, 6'd0, 6'd0},
        '{6'd30, 6'd5,  6'd10, 6'd10, 6'd40, 6'd0,  6'd0, 6'd0},
        '{6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0}
    };

endpackage

`default_nettype wire

### rtl/tour_order_crossover_mutate_cost_top.sv
// ----------------------------------------------------------------------------
// tour_order_crossover_mutate_cost_top
// Order crossover of two parent tours, optional swap mutation and open-path
// cost over the distance table.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   mother, father, cut, mutate, swaps
//   output   out        o_valid / i_stall   child tour, tour cost
//
// five register stages: select, assemble, swap, hop lookup, sum
// one transfer per cycle while the output is not stalled
// reset clears the stage valid bits only
// a stalled output holds the whole pipeline; o_stall follows it in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tour_order_crossover_mutate_cost_top #(
    parameter int NUM_CITIES = tocmc_pkg::NUM_CITIES_DEF,
    localparam int TW = NUM_CITIES * tocmc_pkg::CITY_BITS,
    localparam int CW = $clog2(NUM_CITIES + 1),
    localparam int IW = (NUM_CITIES > 1) ? $clog2(NUM_CITIES) : 1
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [TW-1:0]                   i_mother_tour,
    input  wire  [TW-1:0]                   i_father_tour,
    input  wire  [tocmc_pkg::CITY_BITS-1:0] i_cut_point,
    input  wire                             i_do_mutate,
    input  wire  [tocmc_pkg::CITY_BITS-1:0] i_swap_first,
    input  wire  [tocmc_pkg::CITY_BITS-1:0] i_swap_second,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic [TW-1:0]                   o_child_tour,
    output logic [tocmc_pkg::COST_BITS-1:0] o_tour_cost
);

    logic                  en;
    tocmc_pkg::t_pipe_ctl  ctl_sel;
    tocmc_pkg::t_pipe_ctl  ctl_asm;
    tocmc_pkg::t_pipe_ctl  ctl_cost;

    logic                  s1_vld;
    logic [TW-1:0]         s1_mother;
    logic [TW-1:0]         s1_father;
    logic [CW-1:0]         s1_cut;
    logic [NUM_CITIES-1:0] s1_cand;
    logic                  s1_do_swap;
    logic [IW-1:0]         s1_swap_a;
    logic [IW-1:0]         s1_swap_b;
    logic                  s3_vld;
    logic [TW-1:0]         s3_child;
    logic                  out_vld;

    assign en       = !(out_vld && i_stall);
    assign o_stall  = out_vld && i_stall;
    assign o_valid  = out_vld;
    assign ctl_sel  = '{en: en, vld: i_valid};
    assign ctl_asm  = '{en: en, vld: s1_vld};
    assign ctl_cost = '{en: en, vld: s3_vld};

    tocmc_select #(
        .NUM_CITIES (NUM_CITIES)
    ) u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl_sel),
        .i_mother_tour (i_mother_tour),
        .i_father_tour (i_father_tour),
        .i_cut_point   (i_cut_point),
        .i_do_mutate   (i_do_mutate),
        .i_swap_first  (i_swap_first),
        .i_swap_second (i_swap_second),
        .o_valid       (s1_vld),
        .o_mother_tour (s1_mother),
        .o_father_tour (s1_father),
        .o_cut         (s1_cut),
        .o_cand        (s1_cand),
        .o_do_swap     (s1_do_swap),
        .o_swap_a      (s1_swap_a),
        .o_swap_b      (s1_swap_b)
    );

    tocmc_assemble #(
        .NUM_CITIES (NUM_CITIES)
    ) u_assemble (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl_asm),
        .i_mother_tour (s1_mother),
        .i_father_tour (s1_father),
        .i_cut         (s1_cut),
        .i_cand        (s1_cand),
        .i_do_swap     (s1_do_swap),
        .i_swap_a      (s1_swap_a),
        .i_swap_b      (s1_swap_b),
        .o_valid       (s3_vld),
        .o_child_tour  (s3_child)
    );

    tocmc_cost #(
        .NUM_CITIES (NUM_CITIES)
    ) u_cost (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl_cost),
        .i_child_tour (s3_child),
        .o_valid      (out_vld),
        .o_child_tour (o_child_tour),
        .o_tour_cost  (o_tour_cost)
    );

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

endmodule

`default_nettype wire

### rtl/tocmc_select.sv
// ----------------------------------------------------------------------------
// tocmc_select
// First stage: saturates the cut, marks the kept mother cities and flags the
// father cities that will be appended; checks the swap request.
// ----------------------------------------------------------------------------
`default_nettype none

module tocmc_select #(
    parameter int NUM_CITIES = tocmc_pkg::NUM_CITIES_DEF,
    localparam int TW = NUM_CITIES * tocmc_pkg::CITY_BITS,
    localparam int CW = $clog2(NUM_CITIES + 1),
    localparam int IW = (NUM_CITIES > 1) ? $clog2(NUM_CITIES) : 1
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  tocmc_pkg::t_pipe_ctl                i_ctl,
    input  wire  [TW-1:0]                       i_mother_tour,
    input  wire  [TW-1:0]                       i_father_tour,
    input  wire  [tocmc_pkg::CITY_BITS-1:0]     i_cut_point,
    input  wire                                 i_do_mutate,
    input  wire  [tocmc_pkg::CITY_BITS-1:0]     i_swap_first,
    input  wire  [tocmc_pkg::CITY_BITS-1:0]     i_swap_second,
    output logic                                o_valid,
    output logic [TW-1:0]                       o_mother_tour,
    output logic [TW-1:0]                       o_father_tour,
    output logic [CW-1:0]                       o_cut,
    output logic [NUM_CITIES-1:0]               o_cand,
    output logic                                o_do_swap,
    output logic [IW-1:0]                       o_swap_a,
    output logic [IW-1:0]                       o_swap_b
);

    logic [CW-1:0]                   n_cut;
    logic [tocmc_pkg::NUM_CODES-1:0] mom_used;
    logic [NUM_CITIES-1:0]           n_cand;
    logic                            n_do_swap;
    tocmc_pkg::t_city                mc [NUM_CITIES];
    tocmc_pkg::t_city                fc [NUM_CITIES];

    logic                  r_vld;
    logic [TW-1:0]         r_mother;
    logic [TW-1:0]         r_father;
    logic [CW-1:0]         r_cut;
    logic [NUM_CITIES-1:0] r_cand;
    logic                  r_do_swap;
    logic [IW-1:0]         r_swap_a;
    logic [IW-1:0]         r_swap_b;

    always_comb begin
        for (int p = 0; p < NUM_CITIES; p++) begin
            mc[p] = i_mother_tour[p*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS];
            fc[p] = i_father_tour[p*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS];
        end
        if (int'(i_cut_point) > NUM_CITIES) begin
            n_cut = CW'(NUM_CITIES);
        end else begin
            n_cut = CW'(i_cut_point);
        end
        mom_used = '0;
        for (int p = 0; p < NUM_CITIES; p++) begin
            if (CW'(p) < n_cut) begin
                mom_used[mc[p]] = 1'b1;
            end
        end
        // a father city is appended once, and only if the mother prefix lacks it
        for (int i = 0; i < NUM_CITIES; i++) begin
            n_cand[i] = !mom_used[fc[i]];
            for (int j = 0; j < i; j++) begin
                if (fc[j] == fc[i]) begin
                    n_cand[i] = 1'b0;
                end
            end
        end
        n_do_swap = i_do_mutate && (i_swap_first != i_swap_second)
                    && (int'(i_swap_first) < NUM_CITIES)
                    && (int'(i_swap_second) < NUM_CITIES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_mother  <= i_mother_tour;
            r_father  <= i_father_tour;
            r_cut     <= n_cut;
            r_cand    <= n_cand;
            r_do_swap <= n_do_swap;
            r_swap_a  <= IW'(i_swap_first);
            r_swap_b  <= IW'(i_swap_second);
        end
    end

    assign o_valid       = r_vld;
    assign o_mother_tour = r_mother;
    assign o_father_tour = r_father;
    assign o_cut         = r_cut;
    assign o_cand        = r_cand;
    assign o_do_swap     = r_do_swap;
    assign o_swap_a      = r_swap_a;
    assign o_swap_b      = r_swap_b;

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.en && i_ctl.vld) |=> r_vld)
        else $error("accepted item did not enter first stage");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.en |=> $stable(r_vld) && $stable(r_cand))
        else $error("first stage moved while frozen");

endmodule

`default_nettype wire

### rtl/tocmc_assemble.sv
// ----------------------------------------------------------------------------
// tocmc_assemble
// Second and third stages: places kept and appended cities into the child,
// then applies the swap mutation.
// ----------------------------------------------------------------------------
`default_nettype none

module tocmc_assemble #(
    parameter int NUM_CITIES = tocmc_pkg::NUM_CITIES_DEF,
    localparam int TW = NUM_CITIES * tocmc_pkg::CITY_BITS,
    localparam int CW = $clog2(NUM_CITIES + 1),
    localparam int PW = CW + 1,
    localparam int IW = (NUM_CITIES > 1) ? $clog2(NUM_CITIES) : 1
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  tocmc_pkg::t_pipe_ctl  i_ctl,
    input  wire  [TW-1:0]         i_mother_tour,
    input  wire  [TW-1:0]         i_father_tour,
    input  wire  [CW-1:0]         i_cut,
    input  wire  [NUM_CITIES-1:0] i_cand,
    input  wire                   i_do_swap,
    input  wire  [IW-1:0]         i_swap_a,
    input  wire  [IW-1:0]         i_swap_b,
    output logic                  o_valid,
    output logic [TW-1:0]         o_child_tour
);

    tocmc_pkg::t_city mc [NUM_CITIES];
    tocmc_pkg::t_city fc [NUM_CITIES];
    logic [CW-1:0]    rank [NUM_CITIES];
    logic [PW-1:0]    slot [NUM_CITIES];
    logic [TW-1:0]    n_child2;
    logic [TW-1:0]    n_child3;

    logic             r_vld2;
    logic [TW-1:0]    r_child2;
    logic             r_do_swap2;
    logic [IW-1:0]    r_swap_a2;
    logic [IW-1:0]    r_swap_b2;
    logic             r_vld3;
    logic [TW-1:0]    r_child3;

    always_comb begin
        for (int p = 0; p < NUM_CITIES; p++) begin
            mc[p] = i_mother_tour[p*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS];
            fc[p] = i_father_tour[p*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS];
        end
        // appended order follows the father, packed after the cut
        rank[0] = '0;
        for (int i = 1; i < NUM_CITIES; i++) begin
            rank[i] = rank[i-1] + CW'(i_cand[i-1]);
        end
        for (int i = 0; i < NUM_CITIES; i++) begin
            slot[i] = PW'(i_cut) + PW'(rank[i]);
        end
        n_child2 = '0;
        for (int p = 0; p < NUM_CITIES; p++) begin
            if (CW'(p) < i_cut) begin
                n_child2[p*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS] = mc[p];
            end else begin
                for (int i = 0; i < NUM_CITIES; i++) begin
                    if (i_cand[i] && (slot[i] == PW'(p))) begin
                        n_child2[p*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS] = fc[i];
                    end
                end
            end
        end
    end

    always_comb begin
        n_child3 = r_child2;
        if (r_do_swap2) begin
            n_child3[r_swap_a2*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS] =
                r_child2[r_swap_b2*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS];
            n_child3[r_swap_b2*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS] =
                r_child2[r_swap_a2*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld2 <= i_ctl.vld;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_child2   <= n_child2;
            r_do_swap2 <= i_do_swap;
            r_swap_a2  <= i_swap_a;
            r_swap_b2  <= i_swap_b;
            r_child3   <= n_child3;
        end
    end

    assign o_valid      = r_vld3;
    assign o_child_tour = r_child3;

    a_no_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.en && r_vld2 && !r_do_swap2) |=> (r_child3 == $past(r_child2)))
        else $error("child changed without a swap request");

endmodule

`default_nettype wire

### rtl/tocmc_cost.sv
// ----------------------------------------------------------------------------
// tocmc_cost
// Fourth and fifth stages: looks up the hop distances, then sums them with
// saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tocmc_cost #(
    parameter int NUM_CITIES = tocmc_pkg::NUM_CITIES_DEF,
    localparam int TW = NUM_CITIES * tocmc_pkg::CITY_BITS,
    localparam int HOPS = NUM_CITIES - 1,
    localparam int SW = $clog2(HOPS * tocmc_pkg::DIST_MAX + 1)
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  tocmc_pkg::t_pipe_ctl   i_ctl,
    input  wire  [TW-1:0]          i_child_tour,
    output logic                   o_valid,
    output logic [TW-1:0]          o_child_tour,
    output tocmc_pkg::t_cost       o_tour_cost
);

    tocmc_pkg::t_city  cc [NUM_CITIES];
    tocmc_pkg::t_dist  n_hop [HOPS];
    logic [SW-1:0]     sum;
    tocmc_pkg::t_cost  n_cost;

    logic              r_vld4;
    logic [TW-1:0]     r_child4;
    tocmc_pkg::t_dist  r_hop [HOPS];
    logic              r_vld5;
    logic [TW-1:0]     r_child5;
    tocmc_pkg::t_cost  r_cost5;

    always_comb begin
        for (int p = 0; p < NUM_CITIES; p++) begin
            cc[p] = i_child_tour[p*tocmc_pkg::CITY_BITS +: tocmc_pkg::CITY_BITS];
        end
        for (int h = 0; h < HOPS; h++) begin
            n_hop[h] = tocmc_pkg::DIST_ROM[cc[h]][cc[h+1]];
        end
    end

    always_comb begin
        sum = '0;
        for (int h = 0; h < HOPS; h++) begin
            sum = sum + SW'(r_hop[h]);
        end
        if (int'(sum) > int'(tocmc_pkg::COST_MAX)) begin
            n_cost = tocmc_pkg::COST_MAX;
        end else begin
            n_cost = tocmc_pkg::COST_BITS'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld4 <= i_ctl.vld;
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_child4 <= i_child_tour;
            r_hop    <= n_hop;
            r_child5 <= r_child4;
            r_cost5  <= n_cost;
        end
    end

    assign o_valid      = r_vld5;
    assign o_child_tour = r_child5;
    assign o_tour_cost  = r_cost5;

endmodule

`default_nettype wire
